// ===== hw/rtl/tlqe_pkg.sv =====
`timescale 1ns / 1ps
package tlqe_pkg;
  localparam int VertexIndexBitsDefault = 16;
  localparam int IdxW = 16;
  localparam int PosW = 25;
  localparam int SqW = 34;
  localparam int LenW = 25;
  localparam int QW = 16;

  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_DRAW = 1'b1;
  localparam logic RES_VERTEX = 1'b0;
  localparam logic RES_TRIANGLE = 1'b1;

  typedef struct packed {
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic [7:0] color_index;
    logic [5:0] thickness;
  } line_t;

  typedef struct packed {
    logic kind;
    line_t line;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQRT,
    BK_DIVX,
    BK_DIVY,
    BK_OFFS,
    BK_EMIT
  } bk_state_t;

  function automatic logic [2:0] tri_corner(input logic [2:0] k, input logic [1:0] j);
    logic [2:0] r;
    r = 3'd0;
    case (k)
      3'd0: r = (j == 2'd0) ? 3'd0 : (j == 2'd1) ? 3'd1 : 3'd5;
      3'd1: r = (j == 2'd0) ? 3'd0 : (j == 2'd1) ? 3'd5 : 3'd4;
      3'd2: r = (j == 2'd0) ? 3'd1 : (j == 2'd1) ? 3'd2 : 3'd6;
      3'd3: r = (j == 2'd0) ? 3'd1 : (j == 2'd1) ? 3'd6 : 3'd5;
      3'd4: r = (j == 2'd0) ? 3'd2 : (j == 2'd1) ? 3'd3 : 3'd7;
      default: r = (j == 2'd0) ? 3'd2 : (j == 2'd1) ? 3'd7 : 3'd6;
    endcase
    return r;
  endfunction
endpackage

// ===== hw/rtl/tlqe_if.sv =====
`timescale 1ns / 1ps
interface tlqe_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic signed [15:0] x_start;
  logic signed [15:0] y_start;
  logic signed [15:0] x_end;
  logic signed [15:0] y_end;
  logic [7:0] color_index;
  logic [5:0] thickness;
  modport source(output valid, kind, x_start, y_start, x_end, y_end, color_index,
                 thickness, input ready);
  modport sink(input valid, kind, x_start, y_start, x_end, y_end, color_index,
               thickness, output ready);
endinterface

interface tlqe_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic [15:0] vertex_number;
  logic signed [24:0] pos_x;
  logic signed [24:0] pos_y;
  logic [7:0] vertex_color;
  logic fringe;
  logic [15:0] tri_a;
  logic [15:0] tri_b;
  logic [15:0] tri_c;
  logic last;
  modport source(output valid, result_kind, vertex_number, pos_x, pos_y, vertex_color,
                 fringe, tri_a, tri_b, tri_c, last, input ready);
  modport sink(input valid, result_kind, vertex_number, pos_x, pos_y, vertex_color,
               fringe, tri_a, tri_b, tri_c, last, output ready);
endinterface

// ===== hw/rtl/tlqe_front.sv =====
`timescale 1ns / 1ps
module tlqe_front
  import tlqe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tlqe_in_if.sink in_ch,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);
  // Two-entry queue between the input port and the back end.
  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{kind: in_ch.kind,
                       line: '{x_start: in_ch.x_start, y_start: in_ch.y_start,
                               x_end: in_ch.x_end, y_end: in_ch.y_end,
                               color_index: in_ch.color_index,
                               thickness: in_ch.thickness}};
    end
  end

  property p_no_pop_empty;
    @(posedge clk) disable iff (!rst_n) q_pop |-> cnt_r != 2'd0;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n) cnt_r != 2'd3;
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("queue count out of range");

  property p_full_no_ready;
    @(posedge clk) disable iff (!rst_n) cnt_r == 2'd2 |-> !in_ch.ready;
  endproperty
  a_full_no_ready: assert property (p_full_no_ready) else $error("ready while full");
endmodule

// ===== hw/rtl/tlqe_back.sv =====
`timescale 1ns / 1ps
module tlqe_back
  import tlqe_pkg::*;
#(
  parameter int VERTEX_INDEX_BITS = VertexIndexBitsDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  tlqe_out_if.source out_ch
);
  localparam int CW = (VERTEX_INDEX_BITS < IdxW) ? VERTEX_INDEX_BITS : IdxW;

  bk_state_t st_r, st_nxt;
  line_t ln_r;
  logic signed [16:0] dx_r, dy_r;
  logic [SqW-1:0] rem_r;
  logic [LenW-1:0] root_r;
  logic [4:0] step_r;
  logic [41:0] num_r;
  logic [LenW+1:0] drem_r;
  logic [15:0] quo_r;
  logic [15:0] nx_mag_r, ny_mag_r;
  logic nx_neg_r, ny_neg_r;
  logic [15:0] ox_in_r, oy_in_r, ox_out_r, oy_out_r;
  logic [3:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic [33:0] s_val;

  // Square root of S*2^16 (34+16 bits) one result bit per cycle.
  logic [51:0] sq_rad;
  logic [5:0] sq_shift;
  logic [1:0] sq_pair;
  logic [35:0] sq_cur;
  logic [35:0] sq_t;

  logic [41:0] dv_sh;
  logic [LenW+1:0] dv_cur, dv_den;

  always_comb begin
    s_val = 34'($signed(dx_r) * $signed(dx_r)) + 34'($signed(dy_r) * $signed(dy_r));
  end

  // Sequential work: one multiplier used over OFFS steps.
  logic [15:0] mul_a;
  logic [13:0] mul_b;
  logic [29:0] mul_p;
  logic [15:0] mul_r;
  assign mul_p = mul_a * mul_b;
  assign mul_r = 16'((mul_p + 30'd16384) >> 15);

  always_comb begin
    sq_shift = 6'(2 * (5'd24 - step_r));
    sq_rad = {2'b00, s_val, 16'd0};
    sq_pair = 2'(sq_rad >> sq_shift);
    sq_cur = {rem_r[33:0], sq_pair};
    sq_t = {9'd0, root_r, 2'b01};
  end

  // The quotient stays below 2^16, so the top numerator bits preload the
  // remainder and sixteen steps finish the division.
  always_comb begin
    dv_den = {1'b0, root_r, 1'b0};
    dv_cur = {drem_r[LenW:0], num_r[41]};
    dv_sh = (st_r == BK_DIVX)
            ? 42'({(dy_r[16] ? 17'(-dy_r) : dy_r), 24'd0}) + 42'(root_r)
            : 42'({(dx_r[16] ? 17'(-dx_r) : dx_r), 24'd0}) + 42'(root_r);
  end

  always_comb begin
    unique case (idx_r[1:0])
      2'd0: begin mul_a = nx_mag_r; end
      2'd1: begin mul_a = ny_mag_r; end
      2'd2: begin mul_a = nx_mag_r; end
      default: begin mul_a = ny_mag_r; end
    endcase
    mul_b = idx_r[1] ? (14'({ln_r.thickness, 7'd0}) + 14'd256) :
                       14'({ln_r.thickness, 7'd0});
  end

  // Output register and state advance.
  logic out_fire;
  logic emit_load;
  assign out_fire = out_ch.valid && out_ch.ready;

  logic [1:0] crn;
  logic outer;
  logic signed [24:0] ex, ey;
  logic signed [16:0] offx, offy;
  logic [2:0] tk;
  logic [CW-1:0] ta, tb, tc, vn;

  always_comb begin
    crn = idx_r[1:0];
    outer = (crn == 2'd0) || (crn == 2'd3);
    ex = idx_r[2] ? 25'(ln_r.x_end) <<< 8 : 25'(ln_r.x_start) <<< 8;
    ey = idx_r[2] ? 25'(ln_r.y_end) <<< 8 : 25'(ln_r.y_start) <<< 8;
    ex = idx_r[2] ? {{1{ln_r.x_end[15]}}, ln_r.x_end, 8'd0} :
                    {{1{ln_r.x_start[15]}}, ln_r.x_start, 8'd0};
    ey = idx_r[2] ? {{1{ln_r.y_end[15]}}, ln_r.y_end, 8'd0} :
                    {{1{ln_r.y_start[15]}}, ln_r.y_start, 8'd0};
    offx = outer ? {1'b0, ox_out_r} : {1'b0, ox_in_r};
    offy = outer ? {1'b0, oy_out_r} : {1'b0, oy_in_r};
    if (nx_neg_r) offx = -offx;
    if (ny_neg_r) offy = -offy;
    if (crn[1]) begin
      offx = -offx;
      offy = -offy;
    end
    tk = 3'(idx_r - 4'd8);
    ta = cnt_r + CW'(tri_corner(tk, 2'd0));
    tb = cnt_r + CW'(tri_corner(tk, 2'd1));
    tc = cnt_r + CW'(tri_corner(tk, 2'd2));
    vn = cnt_r + CW'(idx_r[2:0]);
  end

  logic ov_r;
  assign out_ch.valid = ov_r;
  assign emit_load = (st_r == BK_EMIT) && (!ov_r || out_ch.ready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (q_valid && q_cmd.kind == KIND_DRAW) st_nxt = BK_SQRT;
      BK_SQRT: if (s_val == 34'd0) st_nxt = BK_IDLE;
               else if (step_r == 5'd24) st_nxt = BK_DIVX;
      BK_DIVX: if (step_r == 5'd16) st_nxt = BK_DIVY;
      BK_DIVY: if (step_r == 5'd16) st_nxt = BK_OFFS;
      BK_OFFS: if (idx_r == 4'd3) st_nxt = BK_EMIT;
      BK_EMIT: if (emit_load && idx_r == 4'd13) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == BK_IDLE) && q_valid;
  end

  logic [15:0] qsat;
  always_comb begin
    qsat = (quo_r > 16'd32767) ? 16'd32767 : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
      step_r <= '0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_fire && !emit_load) ov_r <= 1'b0;
      unique case (st_r)
        BK_IDLE: begin
          step_r <= '0;
          idx_r <= '0;
          if (q_valid && q_cmd.kind == KIND_BEGIN) cnt_r <= '0;
        end
        BK_SQRT, BK_DIVX: step_r <= (st_nxt != st_r) ? 5'd0 : step_r + 5'd1;
        BK_DIVY: begin
          step_r <= (st_nxt != st_r) ? 5'd0 : step_r + 5'd1;
          idx_r <= '0;
        end
        BK_OFFS: idx_r <= (st_nxt != st_r) ? 4'd0 : idx_r + 4'd1;
        BK_EMIT: if (emit_load) begin
          ov_r <= 1'b1;
          idx_r <= idx_r + 4'd1;
          if (idx_r == 4'd13) cnt_r <= cnt_r + CW'(8);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      BK_IDLE: begin
        ln_r <= q_cmd.line;
        dx_r <= 17'(q_cmd.line.x_end) - 17'(q_cmd.line.x_start);
        dy_r <= 17'(q_cmd.line.y_end) - 17'(q_cmd.line.y_start);
        rem_r <= '0;
        root_r <= '0;
      end
      BK_SQRT: begin
        if (sq_cur >= sq_t) begin
          rem_r <= 34'(sq_cur - sq_t);
          root_r <= {root_r[LenW-2:0], 1'b1};
        end else begin
          rem_r <= 34'(sq_cur);
          root_r <= {root_r[LenW-2:0], 1'b0};
        end
        // Numerator for -dy: |dy|*2^24 + L, formed when the division step loads it.
        num_r <= '0;
        drem_r <= '0;
        quo_r <= '0;
      end
      BK_DIVX, BK_DIVY: begin
        if (step_r == 5'd0) begin
          // Load numerator for this component.
          num_r <= {dv_sh[15:0], 26'd0};
          drem_r <= {1'b0, dv_sh[41:16]};
          quo_r <= '0;
          if (st_r == BK_DIVY) begin
            nx_mag_r <= qsat;
          end
        end else begin
          num_r <= {num_r[40:0], 1'b0};
          if (dv_cur >= dv_den) begin
            drem_r <= dv_cur - dv_den;
            quo_r <= {quo_r[14:0], 1'b1};
          end else begin
            drem_r <= dv_cur;
            quo_r <= {quo_r[14:0], 1'b0};
          end
        end
        nx_neg_r <= (dy_r > 0);
        ny_neg_r <= dx_r[16];
      end
      BK_OFFS: begin
        if (idx_r == 4'd0) ny_mag_r <= qsat;
        unique case (idx_r[1:0])
          2'd0: ox_in_r <= mul_r;
          2'd1: oy_in_r <= mul_r;
          2'd2: ox_out_r <= mul_r;
          default: oy_out_r <= mul_r;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_ch.result_kind <= idx_r[3] ? RES_TRIANGLE : RES_VERTEX;
      out_ch.vertex_number <= idx_r[3] ? 16'd0 : 16'(vn);
      out_ch.pos_x <= idx_r[3] ? 25'd0 : ex + 25'(offx);
      out_ch.pos_y <= idx_r[3] ? 25'd0 : ey + 25'(offy);
      out_ch.vertex_color <= idx_r[3] ? 8'd0 : ln_r.color_index;
      out_ch.fringe <= idx_r[3] ? 1'b0 : outer;
      out_ch.tri_a <= idx_r[3] ? 16'(ta) : 16'd0;
      out_ch.tri_b <= idx_r[3] ? 16'(tb) : 16'd0;
      out_ch.tri_c <= idx_r[3] ? 16'(tc) : 16'd0;
      out_ch.last <= (idx_r == 4'd13);
    end
  end

  property p_emit_only;
    @(posedge clk) disable iff (!rst_n) emit_load |-> st_r == BK_EMIT;
  endproperty
  a_emit_only: assert property (p_emit_only) else $error("load outside emit");

  property p_pop_idle;
    @(posedge clk) disable iff (!rst_n) q_pop |-> st_r == BK_IDLE;
  endproperty
  a_pop_idle: assert property (p_pop_idle) else $error("pop while busy");

  property p_hold;
    @(posedge clk) disable iff (!rst_n) ov_r && !out_ch.ready |=> ov_r;
  endproperty
  a_hold: assert property (p_hold) else $error("result dropped");
endmodule

// ===== hw/rtl/thick_line_quad_expander.sv =====
`timescale 1ns / 1ps
// Expands each draw transaction of nonzero length into 8 vertex and 6 triangle
// results; a zero-length line gives none, and a begin transaction clears the
// vertex count. A 25-step bit-serial square root and two serial divisions for
// the normal dominate the work on a line. A two-entry input queue lets the next
// transaction be taken while one is in work.
module thick_line_quad_expander
  import tlqe_pkg::*;
#(
  parameter int VERTEX_INDEX_BITS = VertexIndexBitsDefault
) (
  input logic clk,
  input logic rst_n,
  tlqe_in_if.sink in_ch,
  tlqe_out_if.source out_ch
);
  logic q_valid, q_pop;
  cmd_t q_cmd;

  tlqe_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  tlqe_back #(.VERTEX_INDEX_BITS(VERTEX_INDEX_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule

// ===== dv/tlqe_tb_if.sv =====
`timescale 1ns / 1ps
// The block's channel interfaces are defined with the RTL in hw/rtl/tlqe_if.sv.
// This file only carries the transaction record that the testbench queues.
package tlqe_tb_pkg;
  typedef struct packed {
    logic result_kind;
    logic [15:0] vertex_number;
    logic signed [24:0] pos_x;
    logic signed [24:0] pos_y;
    logic [7:0] vertex_color;
    logic fringe;
    logic [15:0] tri_a;
    logic [15:0] tri_b;
    logic [15:0] tri_c;
    logic last;
  } vtx_res_t;
endpackage

// ===== dv/tb_thick_line_quad_expander.sv =====
`timescale 1ns / 1ps
module tb_thick_line_quad_expander;
  import tlqe_pkg::*;
  import tlqe_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlqe_in_if in_ch();
  tlqe_out_if out_ch();

  thick_line_quad_expander dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_t pending_cmds[$];
  vtx_res_t expected_results[$];
  logic [15:0] batch_count;
  int mismatches;
  int results_seen;
  int gap_left;
  int burst_left;
  int stall_phase;
  bit hold_sender;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint normal_q15(input longint d, input longint unsigned len);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << 24) + len) / (2 * len);
    if (q > 32767) q = 32767;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint offset_q8(input longint n, input longint hw);
    longint r;
    r = (((n < 0) ? -n : n) * hw + 16384) >>> 15;
    return (n < 0) ? -r : r;
  endfunction

  task automatic expand_line(input cmd_t c);
    longint dx, dy, nx, ny, hw, px, py, ox, oy;
    longint unsigned len;
    int tri_corners[18];
    vtx_res_t r;
    tri_corners = '{0, 1, 5, 0, 5, 4, 1, 2, 6, 1, 6, 5, 2, 3, 7, 2, 7, 6};
    if (c.kind == KIND_BEGIN) begin
      batch_count = '0;
      return;
    end
    dx = longint'(c.line.x_end) - longint'(c.line.x_start);
    dy = longint'(c.line.y_end) - longint'(c.line.y_start);
    if (dx * dx + dy * dy == 0) return;
    len = int_sqrt(longint'(dx * dx + dy * dy) << 16);
    nx = normal_q15(-dy, len);
    ny = normal_q15(dx, len);
    for (int i = 0; i < 8; i++) begin
      r = '{default: '0};
      hw = c.line.thickness * 128 + (((i & 3) == 0 || (i & 3) == 3) ? 256 : 0);
      ox = offset_q8(nx, hw);
      oy = offset_q8(ny, hw);
      px = ((i < 4) ? longint'(c.line.x_start) : longint'(c.line.x_end)) * 256;
      py = ((i < 4) ? longint'(c.line.y_start) : longint'(c.line.y_end)) * 256;
      if ((i & 3) < 2) begin
        px += ox;
        py += oy;
      end else begin
        px -= ox;
        py -= oy;
      end
      r.result_kind = RES_VERTEX;
      r.vertex_number = batch_count + 16'(i);
      r.pos_x = px[24:0];
      r.pos_y = py[24:0];
      r.vertex_color = c.line.color_index;
      r.fringe = ((i & 3) == 0 || (i & 3) == 3);
      expected_results.push_back(r);
    end
    for (int k = 0; k < 6; k++) begin
      r = '{default: '0};
      r.result_kind = RES_TRIANGLE;
      r.tri_a = batch_count + 16'(tri_corners[3 * k]);
      r.tri_b = batch_count + 16'(tri_corners[3 * k + 1]);
      r.tri_c = batch_count + 16'(tri_corners[3 * k + 2]);
      r.last = (k == 5);
      expected_results.push_back(r);
    end
    batch_count = batch_count + 16'd8;
  endtask

  function automatic cmd_t make_line(input int xs, input int ys, input int xe, input int ye,
                                     input int col, input int th);
    cmd_t c;
    c.kind = KIND_DRAW;
    c.line.x_start = 16'(xs);
    c.line.y_start = 16'(ys);
    c.line.x_end = 16'(xe);
    c.line.y_end = 16'(ye);
    c.line.color_index = 8'(col);
    c.line.thickness = 6'(th);
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int xs, ys, sp;
    c = make_line(0, 0, 0, 0, $urandom_range(0, 255), $urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0: c.kind = KIND_BEGIN;
      1: begin
        xs = $urandom_range(0, 65535);
        ys = $urandom_range(0, 65535);
        c.line.x_start = 16'(xs);
        c.line.y_start = 16'(ys);
        c.line.x_end = 16'(xs);
        c.line.y_end = 16'(ys);
      end
      2, 3, 4: begin
        c.line.x_start = 16'($urandom);
        c.line.y_start = 16'($urandom);
        c.line.x_end = 16'($urandom);
        c.line.y_end = 16'($urandom);
      end
      default: begin
        sp = 1 << $urandom_range(0, 10);
        xs = $urandom_range(0, 65535);
        ys = $urandom_range(0, 65535);
        c.line.x_start = 16'(xs);
        c.line.y_start = 16'(ys);
        c.line.x_end = 16'(xs + $urandom_range(0, 2 * sp) - sp);
        c.line.y_end = 16'(ys + $urandom_range(0, 2 * sp) - sp);
      end
    endcase
    return c;
  endfunction

  // Driver: bursts with random gaps; a transaction leaves the queue on handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expand_line(pending_cmds.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
      end else if (hold_sender || pending_cmds.size() == 0 ||
                   (in_ch.valid && in_ch.ready && pending_cmds.size() == 0)) begin
        in_ch.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        {in_ch.kind, in_ch.x_start, in_ch.y_start, in_ch.x_end, in_ch.y_end,
         in_ch.color_index, in_ch.thickness} <= pending_cmds[0];
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    vtx_res_t want, got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ch.ready <= (stall_phase % 512 < 128) || ((stall_phase * 7) % 11 > 3);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.result_kind, out_ch.vertex_number, out_ch.pos_x, out_ch.pos_y,
                out_ch.vertex_color, out_ch.fringe, out_ch.tri_a, out_ch.tri_b,
                out_ch.tri_c, out_ch.last};
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("Unexpected result transaction: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (want !== got) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.kind, in_ch.x_start, in_ch.y_start, in_ch.x_end, in_ch.y_end,
     in_ch.color_index, in_ch.thickness} = '0;
    out_ch.ready = 1'b0;
    batch_count = '0;
    mismatches = 0;
    results_seen = 0;
    hold_sender = 1'b0;
    stall_phase = 0;

    pending_cmds.push_back(make_line(0, 0, 10, 0, 0, 0));
    pending_cmds.push_back(make_line(0, 0, 0, -10, 255, 63));
    pending_cmds.push_back(make_line(-32768, -32768, 32767, 32767, 170, 63));
    pending_cmds.push_back(make_line(32767, -32768, -32768, 32767, 85, 1));
    pending_cmds.push_back(make_line(32767, 32767, -32768, -32768, 1, 42));
    pending_cmds.push_back(make_line(5, 5, 5, 5, 7, 9));
    pending_cmds.push_back(make_line(0, 0, 1, 1, 128, 21));
    pending_cmds.push_back(make_line(-32768, 0, 32767, 0, 64, 63));
    pending_cmds.push_back(make_line(0, 32767, 0, -32768, 32, 0));
    pending_cmds.push_back(make_line(3, -4, 0, 0, 200, 5));
    pending_cmds.push_back(make_line(0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_line(0, 0, 0, 0, 0, 0));
    pending_cmds[$].kind = KIND_BEGIN;
    pending_cmds.push_back(make_line(100, 200, 101, 200, 99, 63));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_cmds.size() == 0);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    hold_sender = 1'b0;
    for (int n = 0; n < 250; n++) pending_cmds.push_back(random_cmd());
    wait (pending_cmds.size() == 0);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Ran directed extreme lines, a full drain and 250 random transactions;");
    $display("%0d results checked, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_thick_line_quad_expander: PASS");
    end else begin
      $display("tb_thick_line_quad_expander: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_thick_line_quad_expander: FAIL");
    $finish;
  end
endmodule

// ===== thick_line_quad_expander.f =====
hw/rtl/tlqe_pkg.sv
hw/rtl/tlqe_if.sv
hw/rtl/tlqe_front.sv
hw/rtl/tlqe_back.sv
hw/rtl/thick_line_quad_expander.sv
dv/tlqe_tb_if.sv
dv/tb_thick_line_quad_expander.sv
